// ===== rtl/panel_keys_button_encoder_scanner_assert.svh =====
// assertion macros shared by the panel key scanner modules
`ifndef PANEL_KEYS_BUTTON_ENCODER_SCANNER_ASSERT_SVH
`define PANEL_KEYS_BUTTON_ENCODER_SCANNER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PKBES_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("pkbes same-cycle check failed");

// next-cycle implication, disabled during reset
`define PKBES_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("pkbes next-cycle check failed");

`endif

// ===== rtl/pkbes_pkg.sv =====
// shared types, constants and key remap function for the panel key scanner
package pkbes_pkg;

   localparam int PIN_COUNT  = 32;
   localparam int KEY_COUNT  = 25;
   localparam int KEY_BASE   = PIN_COUNT - KEY_COUNT;
   localparam int BUTTON_PIN = 4;
   localparam int PHASE_LSB  = 5;

   typedef logic [PIN_COUNT-1:0] pins_type;
   typedef logic [KEY_COUNT-1:0] keys_type;
   typedef logic [7:0]           run_type;
   typedef logic [1:0]           phase_type;

   localparam run_type THRESHOLD_RESET = 8'd10;
   localparam run_type RUN_MAX         = 8'hFF;

   localparam phase_type PHASE_LOW  = 2'b00;
   localparam phase_type PHASE_A    = 2'b01;
   localparam phase_type PHASE_B    = 2'b10;
   localparam phase_type PHASE_HIGH = 2'b11;

   typedef struct packed {
      logic load;
      logic update;
   } step_type;

   function automatic keys_type remap_keys(pins_type pins);
      keys_type word;
      word[24]    = pins[KEY_BASE];
      word[23:16] = pins[15:8];
      word[15:8]  = pins[23:16];
      word[7:0]   = pins[31:24];
      return ~word;
   endfunction

endpackage

// ===== rtl/pkbes_req_if.sv =====
// request channel carrying one pin sample per transaction
interface pkbes_req_if;
   logic                valid;
   logic                ready;
   pkbes_pkg::pins_type pin_word;

   modport source (output valid, output pin_word, input ready);
   modport sink (input valid, input pin_word, output ready);
endinterface

// ===== rtl/pkbes_rsp_if.sv =====
// response channel carrying key, button and encoder status per transaction
interface pkbes_rsp_if;
   logic                valid;
   logic                ready;
   pkbes_pkg::keys_type key_states;
   logic                keys_changed;
   logic                button_pressed;
   logic                button_event;
   logic                turn_clockwise;
   logic                turn_event;

   modport source (output valid, output key_states, output keys_changed,
                   output button_pressed, output button_event,
                   output turn_clockwise, output turn_event, input ready);
   modport sink (input valid, input key_states, input keys_changed,
                 input button_pressed, input button_event,
                 input turn_clockwise, input turn_event, output ready);
endinterface

// ===== rtl/pkbes_keys.sv =====
// key word change detect, remap and hold
module pkbes_keys (
   input  logic                clock,
   input  logic                reset,
   input  pkbes_pkg::step_type step,
   input  pkbes_pkg::pins_type pins,
   output pkbes_pkg::keys_type key_states,
   output logic                keys_changed
);

   pkbes_pkg::pins_type prev_pins_ff;
   pkbes_pkg::pins_type prev_pins_in;
   pkbes_pkg::keys_type held_keys_ff;
   pkbes_pkg::keys_type held_keys_in;

   always_comb begin
      keys_changed = step.update && (pins != prev_pins_ff);
      held_keys_in = keys_changed ? pkbes_pkg::remap_keys(pins) : held_keys_ff;
      prev_pins_in = step.load ? pins : prev_pins_ff;
      key_states   = held_keys_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff <= '0;
         held_keys_ff <= '0;
      end else begin
         prev_pins_ff <= prev_pins_in;
         held_keys_ff <= held_keys_in;
      end
   end

endmodule

// ===== rtl/pkbes_button.sv =====
// push button debounce with saturating press and release run counters
module pkbes_button (
   input  logic                clock,
   input  logic                reset,
   input  pkbes_pkg::step_type step,
   input  pkbes_pkg::pins_type pins,
   input  pkbes_pkg::run_type  threshold,
   output logic                button_pressed,
   output logic                button_event
);

`include "panel_keys_button_encoder_scanner_assert.svh"

   pkbes_pkg::run_type press_run_ff;
   pkbes_pkg::run_type press_run_in;
   pkbes_pkg::run_type release_run_ff;
   pkbes_pkg::run_type release_run_in;
   logic               level_ff;
   logic               level_in;
   logic               flip;

   always_comb begin
      press_run_in   = press_run_ff;
      release_run_in = release_run_ff;
      level_in       = level_ff;
      flip           = 1'b0;
      if (step.update) begin
         if (!pins[pkbes_pkg::BUTTON_PIN]) begin
            press_run_in   = (press_run_ff == pkbes_pkg::RUN_MAX) ?
                             pkbes_pkg::RUN_MAX : press_run_ff + 8'd1;
            release_run_in = '0;
            if ((press_run_in > threshold) && !level_ff) begin
               level_in = 1'b1;
               flip     = 1'b1;
            end
         end else begin
            release_run_in = (release_run_ff == pkbes_pkg::RUN_MAX) ?
                             pkbes_pkg::RUN_MAX : release_run_ff + 8'd1;
            press_run_in   = '0;
            if ((release_run_in > threshold) && level_ff) begin
               level_in = 1'b0;
               flip     = 1'b1;
            end
         end
      end
      button_pressed = level_in;
      button_event   = flip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_run_ff   <= '0;
         release_run_ff <= '0;
         level_ff       <= 1'b0;
      end else begin
         press_run_ff   <= press_run_in;
         release_run_ff <= release_run_in;
         level_ff       <= level_in;
      end
   end

   // an event always toggles the debounced level
   `PKBES_ASSERT_NEXT(a_event_toggles, clock, reset, flip, level_ff != $past(level_ff))
   // the level never changes without an event
   `PKBES_ASSERT_NEXT(a_level_needs_event, clock, reset, !flip, level_ff == $past(level_ff))
   // only one run counter is active after an update
   `PKBES_ASSERT_NEXT(a_one_run, clock, reset, step.update,
                      (press_run_ff == '0) || (release_run_ff == '0))

endmodule

// ===== rtl/pkbes_encoder.sv =====
// quadrature decode of the rotary encoder phase pair
module pkbes_encoder (
   input  logic                clock,
   input  logic                reset,
   input  pkbes_pkg::step_type step,
   input  pkbes_pkg::pins_type pins,
   output logic                turn_clockwise,
   output logic                turn_event
);

`include "panel_keys_button_encoder_scanner_assert.svh"

   pkbes_pkg::phase_type phase;
   pkbes_pkg::phase_type prev_phase_ff;
   pkbes_pkg::phase_type prev_phase_in;
   logic                 direction_ff;
   logic                 direction_in;
   logic                 turn;

   always_comb begin
      phase         = pins[pkbes_pkg::PHASE_LSB +: 2];
      prev_phase_in = prev_phase_ff;
      direction_in  = direction_ff;
      turn          = 1'b0;
      if (step.update) begin
         prev_phase_in = phase;
         if (prev_phase_ff == pkbes_pkg::PHASE_LOW) begin
            if (phase == pkbes_pkg::PHASE_B) begin
               direction_in = 1'b1;
               turn         = 1'b1;
            end else if (phase == pkbes_pkg::PHASE_A) begin
               direction_in = 1'b0;
               turn         = 1'b1;
            end
         end else if (prev_phase_ff == pkbes_pkg::PHASE_HIGH) begin
            if (phase == pkbes_pkg::PHASE_A) begin
               direction_in = 1'b1;
               turn         = 1'b1;
            end else if (phase == pkbes_pkg::PHASE_B) begin
               direction_in = 1'b0;
               turn         = 1'b1;
            end
         end
      end
      turn_clockwise = direction_in;
      turn_event     = turn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phase_ff <= pkbes_pkg::PHASE_LOW;
         direction_ff  <= 1'b0;
      end else begin
         prev_phase_ff <= prev_phase_in;
         direction_ff  <= direction_in;
      end
   end

   // a turn needs a phase change out of a detent
   `PKBES_ASSERT_NOW(a_turn_from_detent, clock, reset, turn,
                     (phase != prev_phase_ff) &&
                     ((prev_phase_ff == pkbes_pkg::PHASE_LOW) ||
                      (prev_phase_ff == pkbes_pkg::PHASE_HIGH)))
   // direction only moves with a turn
   `PKBES_ASSERT_NEXT(a_dir_needs_turn, clock, reset, !turn,
                      direction_ff == $past(direction_ff))

endmodule

// ===== rtl/panel_keys_button_encoder_scanner.sv =====
// top level of the panel key, push button and rotary encoder scanner
// a request is registered in the input stage and its status in the output register, which drives the response
// throughput: one transaction per cycle while the response side keeps up
// the input register refills while a finished response still waits
// reset clears control, counters, history and sets the debounce threshold to 10
// the first transaction after reset only primes the pin history
module panel_keys_button_encoder_scanner (
   input  logic        clock,
   input  logic        reset,
   pkbes_req_if.sink   req_chan,
   pkbes_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

`include "panel_keys_button_encoder_scanner_assert.svh"

   logic                in_valid_ff;
   logic                in_valid_in;
   pkbes_pkg::pins_type in_pins_ff;
   logic                primed_ff;
   logic                primed_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   pkbes_pkg::run_type  threshold_ff;
   pkbes_pkg::run_type  threshold_in;
   logic                advance;
   logic                accept;
   pkbes_pkg::step_type step;

   pkbes_pkg::keys_type key_states_nxt;
   logic                keys_changed_nxt;
   logic                button_pressed_nxt;
   logic                button_event_nxt;
   logic                turn_clockwise_nxt;
   logic                turn_event_nxt;

   pkbes_pkg::keys_type key_states_ff;
   logic                keys_changed_ff;
   logic                button_pressed_ff;
   logic                button_event_ff;
   logic                turn_clockwise_ff;
   logic                turn_event_ff;

   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
      accept       = req_chan.valid && req_chan.ready;
      step.load    = advance;
      step.update  = advance && primed_ff;
      in_valid_in  = accept || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      primed_in    = primed_ff || advance;
      threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;
   end

   assign req_chan.ready = !in_valid_ff || advance;

   pkbes_keys u_keys (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .pins         (in_pins_ff),
      .key_states   (key_states_nxt),
      .keys_changed (keys_changed_nxt)
   );

   pkbes_button u_button (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .pins           (in_pins_ff),
      .threshold      (threshold_ff),
      .button_pressed (button_pressed_nxt),
      .button_event   (button_event_nxt)
   );

   pkbes_encoder u_encoder (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .pins           (in_pins_ff),
      .turn_clockwise (turn_clockwise_nxt),
      .turn_event     (turn_event_nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         primed_ff    <= 1'b0;
         threshold_ff <= pkbes_pkg::THRESHOLD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         primed_ff    <= primed_in;
         threshold_ff <= threshold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_pins_ff <= req_chan.pin_word;
      end
      if (advance) begin
         key_states_ff     <= key_states_nxt;
         keys_changed_ff   <= keys_changed_nxt;
         button_pressed_ff <= button_pressed_nxt;
         button_event_ff   <= button_event_nxt;
         turn_clockwise_ff <= turn_clockwise_nxt;
         turn_event_ff     <= turn_event_nxt;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.key_states     = key_states_ff;
   assign rsp_chan.keys_changed   = keys_changed_ff;
   assign rsp_chan.button_pressed = button_pressed_ff;
   assign rsp_chan.button_event   = button_event_ff;
   assign rsp_chan.turn_clockwise = turn_clockwise_ff;
   assign rsp_chan.turn_event     = turn_event_ff;

   // priming transaction reports no events
   `PKBES_ASSERT_NEXT(a_prime_quiet, clock, reset, advance && !primed_ff,
                      !keys_changed_ff && !button_event_ff && !turn_event_ff)
   // a full input stage that cannot move blocks new requests
   `PKBES_ASSERT_NOW(a_full_blocks, clock, reset, in_valid_ff && !advance, !req_chan.ready)
   // a waiting response is never overwritten
   `PKBES_ASSERT_NOW(a_no_overwrite, clock, reset, out_valid_ff && !rsp_chan.ready, !advance)

endmodule

// ===== tb/sv/panel_keys_button_encoder_scanner_test.sv =====
// testbench for the panel key, push button and rotary encoder scanner
`timescale 1ns / 100ps

module panel_keys_button_encoder_scanner_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      pkbes_pkg::keys_type key_states;
      logic                keys_changed;
      logic                button_pressed;
      logic                button_event;
      logic                turn_clockwise;
      logic                turn_event;
   } status_type;

   class key_scan_scoreboard;
      pkbes_pkg::run_type   threshold;
      pkbes_pkg::pins_type  last_pins;
      bit                   primed;
      pkbes_pkg::keys_type  keys;
      bit                   pressed;
      pkbes_pkg::run_type   press_run;
      pkbes_pkg::run_type   release_run;
      pkbes_pkg::phase_type last_phase;
      bit                   clockwise;
      status_type           pending[$];
      int                   errors;

      function new();
         threshold   = pkbes_pkg::THRESHOLD_RESET;
         last_pins   = '0;
         primed      = 0;
         keys        = '0;
         pressed     = 0;
         press_run   = '0;
         release_run = '0;
         last_phase  = pkbes_pkg::PHASE_LOW;
         clockwise   = 0;
         errors      = 0;
      endfunction

      function void note_sample(pkbes_pkg::pins_type pins);
         status_type           s;
         pkbes_pkg::phase_type ph;
         pkbes_pkg::keys_type  w;
         s = '0;
         if (!primed) begin
            primed    = 1;
            last_pins = pins;
         end else begin
            if (pins != last_pins) begin
               // keys are active low, bytes of the pin word come in reverse order
               w[24] = pins[pkbes_pkg::KEY_BASE];
               for (int i = 0; i < 8; i++) begin
                  w[16+i] = pins[8+i];
                  w[8+i]  = pins[16+i];
                  w[i]    = pins[24+i];
               end
               keys = ~w;
               s.keys_changed = 1;
            end
            last_pins = pins;

            if (!pins[pkbes_pkg::BUTTON_PIN]) begin
               if (press_run != pkbes_pkg::RUN_MAX) press_run++;
               release_run = '0;
               if (press_run > threshold && !pressed) begin
                  pressed = 1;
                  s.button_event = 1;
               end
            end else begin
               if (release_run != pkbes_pkg::RUN_MAX) release_run++;
               press_run = '0;
               if (release_run > threshold && pressed) begin
                  pressed = 0;
                  s.button_event = 1;
               end
            end

            ph = pins[pkbes_pkg::PHASE_LSB +: 2];
            if (ph != last_phase) begin
               if (last_phase == pkbes_pkg::PHASE_LOW) begin
                  if (ph == pkbes_pkg::PHASE_B) begin clockwise = 1; s.turn_event = 1; end
                  if (ph == pkbes_pkg::PHASE_A) begin clockwise = 0; s.turn_event = 1; end
               end else if (last_phase == pkbes_pkg::PHASE_HIGH) begin
                  if (ph == pkbes_pkg::PHASE_A) begin clockwise = 1; s.turn_event = 1; end
                  if (ph == pkbes_pkg::PHASE_B) begin clockwise = 0; s.turn_event = 1; end
               end
               last_phase = ph;
            end
         end
         s.key_states     = keys;
         s.button_pressed = pressed;
         s.turn_clockwise = clockwise;
         pending.push_back(s);
      endfunction

      function void check_status(status_type got);
         status_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected response: keys %h chg %b btn %b bev %b cw %b tev %b",
                        got.key_states, got.keys_changed, got.button_pressed,
                        got.button_event, got.turn_clockwise, got.turn_event);
            return;
         end
         want = pending.pop_front();
         if (got.key_states !== want.key_states || got.keys_changed !== want.keys_changed ||
             got.button_pressed !== want.button_pressed ||
             got.button_event !== want.button_event ||
             got.turn_clockwise !== want.turn_clockwise ||
             got.turn_event !== want.turn_event) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("mismatch expected: keys %h chg %b btn %b bev %b cw %b tev %b",
                        want.key_states, want.keys_changed, want.button_pressed,
                        want.button_event, want.turn_clockwise, want.turn_event);
               $display("         actual:   keys %h chg %b btn %b bev %b cw %b tev %b",
                        got.key_states, got.keys_changed, got.button_pressed,
                        got.button_event, got.turn_clockwise, got.turn_event);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int unsigned cycle_count = 0;

   key_scan_scoreboard sb = new();

   // stimulus generator state
   logic [24:0] gen_keys = '1;
   logic [3:0]  gen_low = '0;
   logic        gen_button = 1'b1;
   int          button_left = 0;
   int          gen_step = 0;
   int          gen_dir = 1;

   pkbes_req_if req_bus();
   pkbes_rsp_if rsp_bus();

   panel_keys_button_encoder_scanner dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      status_type got;
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.key_states     = rsp_bus.key_states;
            got.keys_changed   = rsp_bus.keys_changed;
            got.button_pressed = rsp_bus.button_pressed;
            got.button_event   = rsp_bus.button_event;
            got.turn_clockwise = rsp_bus.turn_clockwise;
            got.turn_event     = rsp_bus.turn_event;
            sb.check_status(got);
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            sb.note_sample(req_bus.pin_word);
      end
   end

   function automatic pkbes_pkg::pins_type make_pins(logic [24:0] keys,
                                                     pkbes_pkg::phase_type ph,
                                                     logic button, logic [3:0] low);
      return {keys, ph, button, low};
   endfunction

   // button runs around the threshold, encoder walking the gray sequence,
   // keys mostly held, with some glitches, jumps and raw noise mixed in
   function automatic pkbes_pkg::pins_type next_sample();
      pkbes_pkg::phase_type walk [4];
      walk = '{pkbes_pkg::PHASE_LOW, pkbes_pkg::PHASE_A, pkbes_pkg::PHASE_HIGH,
               pkbes_pkg::PHASE_B};
      if ($urandom_range(99) < 3) return $urandom();
      if (button_left == 0) begin
         gen_button = ~gen_button;
         if ($urandom_range(3) == 0) button_left = $urandom_range(1, 3);
         else button_left = $urandom_range(1, int'(sb.threshold) + 4);
      end
      button_left--;
      case ($urandom_range(19))
         0: gen_dir = -gen_dir;
         1, 2: ;
         3: gen_step = gen_step + 2;
         default: gen_step = gen_step + gen_dir;
      endcase
      gen_step = (gen_step % 4 + 4) % 4;
      case ($urandom_range(19))
         0: gen_keys = '0;
         1: gen_keys = '1;
         2, 3, 4: gen_keys = 25'($urandom());
         5: gen_keys[$urandom_range(24)] ^= 1'b1;
         6, 7: gen_low = 4'($urandom());
         default: ;
      endcase
      return make_pins(gen_keys, walk[gen_step], gen_button, gen_low);
   endfunction

   task automatic send_sample(pkbes_pkg::pins_type pins);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.pin_word <= pins;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic wait_for_responses();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(pkbes_pkg::run_type value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.threshold = value;
   endtask

   task automatic run_phase(pkbes_pkg::run_type thr, int count, int idle, int stall);
      write_threshold(thr);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) send_sample(next_sample());
      wait_for_responses();
   endtask

   initial begin
      pkbes_pkg::pins_type directed[$];
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.pin_word = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // prime, extremes, encoder walk both ways, jumps, a press, then a release too short to debounce
      directed.push_back(32'h0000_0000);
      directed.push_back(32'hFFFF_FFFF);
      directed.push_back(32'hFFFF_FFFF);
      directed.push_back(32'h0000_0000);
      directed.push_back(make_pins(25'h1000000, pkbes_pkg::PHASE_B, 1'b0, 4'h0));
      directed.push_back(make_pins(25'h0000001, pkbes_pkg::PHASE_HIGH, 1'b0, 4'h0));
      directed.push_back(make_pins(25'h0000001, pkbes_pkg::PHASE_A, 1'b0, 4'h9));
      directed.push_back(make_pins(25'h1555555, pkbes_pkg::PHASE_LOW, 1'b0, 4'h6));
      directed.push_back(make_pins(25'h0AAAAAA, pkbes_pkg::PHASE_A, 1'b0, 4'h6));
      directed.push_back(make_pins(25'h1FFFFFF, pkbes_pkg::PHASE_HIGH, 1'b0, 4'hF));
      directed.push_back(make_pins(25'h0F0F0F0, pkbes_pkg::PHASE_B, 1'b0, 4'h3));
      directed.push_back(make_pins(25'h0000000, pkbes_pkg::PHASE_LOW, 1'b0, 4'hC));
      directed.push_back(make_pins(25'h0000000, pkbes_pkg::PHASE_HIGH, 1'b0, 4'hC));
      directed.push_back(make_pins(25'h0000000, pkbes_pkg::PHASE_LOW, 1'b0, 4'hC));
      directed.push_back(make_pins(25'h1FFFFFF, pkbes_pkg::PHASE_LOW, 1'b1, 4'hF));
      directed.push_back(make_pins(25'h1FFFFFF, pkbes_pkg::PHASE_LOW, 1'b1, 4'hF));
      idle_pct  = 22;
      stall_pct = 22;
      foreach (directed[i]) send_sample(directed[i]);
      wait_for_responses();

      run_phase(8'd0, 150, 0, 0);
      run_phase(8'd3, 150, 52, 0);
      run_phase(8'd12, 150, 0, 52);
      run_phase(8'd254, 300, 22, 22);
      run_phase(8'd255, 250, 0, 0);
      run_phase(8'd1, 100, 52, 52);
      repeat (10) @(posedge clock);

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pkbes_pkg.sv
rtl/pkbes_req_if.sv
rtl/pkbes_rsp_if.sv
rtl/pkbes_keys.sv
rtl/pkbes_button.sv
rtl/pkbes_encoder.sv
rtl/panel_keys_button_encoder_scanner.sv
tb/sv/panel_keys_button_encoder_scanner_test.sv
